### hdl/bgs_pkg.sv
// Shared types, constants and codes of the bilateral grid splat unit.
// No dependencies; every other file imports this package.
package bgs_pkg;

  localparam int DIMS        = 7;
  localparam int GRID_DEPTH  = 65536;
  localparam int NUM_CLASSES = 2;
  localparam int FRAC_BITS   = 10;

  localparam int NUM_CFG   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_W    = 5;
  localparam int COORD_W   = 16;
  localparam int VAL_W     = 8;
  localparam int VIDX_W    = 16;
  localparam int SUM_W     = 40;

  localparam int IP_W     = COORD_W - FRAC_BITS;
  localparam int POS_W    = IP_W + 2;
  localparam int WT_W     = FRAC_BITS + 1;
  localparam int STR_W    = SIZE_W * DIMS;
  localparam int IDX_W    = POS_W + STR_W + 3;
  localparam int ADDR_W   = $clog2(GRID_DEPTH);
  localparam int PROD_W   = WT_W + VAL_W;
  localparam int CSHR     = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int CSHL     = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int CON_W    = PROD_W + CSHL;
  localparam int SETTLE_W = $clog2(DIMS + 1);
  localparam logic [WT_W-1:0] W_ONE = WT_W'(1) << FRAC_BITS;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

  typedef enum logic {
    REQ_SPLAT = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  typedef enum logic {
    WK_IDLE,
    WK_SPLAT
  } walk_state_t;

  typedef struct packed {
    logic                req_type;
    logic [COORD_W-1:0]  coord_d0;
    logic [COORD_W-1:0]  coord_d1;
    logic [COORD_W-1:0]  coord_d2;
    logic [COORD_W-1:0]  coord_d3;
    logic [COORD_W-1:0]  coord_d4;
    logic [COORD_W-1:0]  coord_d5;
    logic [COORD_W-1:0]  coord_d6;
    logic [VAL_W-1:0]    value_class0;
    logic [VAL_W-1:0]    value_class1;
    logic [VIDX_W-1:0]   vertex_index;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_class0;
    logic [SUM_W-1:0] sum_class1;
    logic             dropped_flag;
  } out_item_t;

  // Classified item as it waits between front and walker.
  typedef struct packed {
    logic                          is_read;
    logic [DIMS-1:0][IP_W-1:0]     ip;
    logic [DIMS-1:0][FRAC_BITS-1:0] fr;
    logic [VAL_W-1:0]              val0;
    logic [VAL_W-1:0]              val1;
    logic [VIDX_W-1:0]             vertex;
  } work_t;

  // One store access from walker to accumulator.
  typedef struct packed {
    logic              vld;
    logic              rd;
    logic              zero;
    logic              sticky;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  con0;
    logic [SUM_W-1:0]  con1;
  } acc_req_t;

  typedef struct packed {
    logic clearing;
    logic out_full;
  } acc_stat_t;

endpackage

### hdl/bgs_front.sv
// Front end: accepts input beats, classifies them and queues them.
// Depends on bgs_pkg.
module bgs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  bgs_pkg::in_item_t in_item,
  input  logic              clearing,
  input  logic              deq,
  output logic              q_empty,
  output bgs_pkg::work_t    head
);
  import bgs_pkg::*;

  work_t                       q_r [2];
  logic                        wr_ptr_r, rd_ptr_r;
  logic [1:0]                  cnt_r;
  work_t                       wk;
  logic [6:0][COORD_W-1:0]     cv;
  logic                        push_ok;

  assign cv = {in_item.coord_d6, in_item.coord_d5, in_item.coord_d4, in_item.coord_d3,
               in_item.coord_d2, in_item.coord_d1, in_item.coord_d0};

  always_comb begin
    wk.is_read = (in_item.req_type == REQ_READ);
    for (int j = 0; j < DIMS; j++) begin
      wk.ip[j] = cv[j][COORD_W-1:FRAC_BITS];
      wk.fr[j] = cv[j][FRAC_BITS-1:0];
    end
    wk.val0   = in_item.value_class0;
    wk.val1   = in_item.value_class1;
    wk.vertex = in_item.vertex_index;
  end

  assign in_full = (cnt_r == 2'd2) || clearing;
  assign push_ok = in_push && !in_full;
  assign q_empty = (cnt_r == 2'd0);
  assign head    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_ptr_r] <= wk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= !wr_ptr_r;
      if (deq) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(deq);
    end
  end

endmodule

### hdl/bgs_walk.sv
// Back end sequencer: size registers, strides, corner walk and the
// weight/index pipeline that issues store accesses. Depends on bgs_pkg.
module bgs_walk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgs_pkg::SIZE_W-1:0]       cfg_data,
  input  logic                             q_empty,
  input  bgs_pkg::work_t                   head,
  output logic                             deq,
  input  bgs_pkg::acc_stat_t               stat,
  output bgs_pkg::acc_req_t                req
);
  import bgs_pkg::*;

  logic [SIZE_W-1:0]   size_r   [NUM_CFG];
  logic [STR_W-1:0]    stride_r [DIMS];
  logic [SETTLE_W-1:0] settle_r;

  walk_state_t         state_r, state_nxt;
  work_t               item_r;
  logic [DIMS-1:0]     corner_r;
  logic                sticky_r;
  acc_req_t            req_r;

  logic                    pv_r [DIMS];
  logic [WT_W-1:0]         pw_r [DIMS];
  logic signed [IDX_W-1:0] pi_r [DIMS];
  logic [DIMS-1:0]         pc_r [DIMS];

  logic                    sv [DIMS];
  logic [WT_W-1:0]         sw [DIMS];
  logic signed [IDX_W-1:0] si [DIMS];
  logic [DIMS-1:0]         sc [DIMS];
  logic [WT_W-1:0]         nw [DIMS];
  logic signed [IDX_W-1:0] ni [DIMS];

  logic pipe_busy, start_splat, start_read, inject;
  logic cfg_we;

  assign cfg_we = cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CFG));

  // Size registers, and a settle counter that restarts on each write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CFG; k++) size_r[k] <= SIZE_RESET;
      settle_r <= SETTLE_W'(DIMS);
    end else begin
      if (cfg_we) begin
        size_r[cfg_index] <= cfg_data;
        settle_r <= SETTLE_W'(DIMS);
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    stride_r[0] <= STR_W'(1);
    for (int j = 1; j < DIMS; j++)
      stride_r[j] <= STR_W'(stride_r[j-1] * size_r[j-1]);
  end

  // One stage per dimension: fold in the factor and the index term.
  for (genvar j = 0; j < DIMS; j++) begin : g_stage
    logic [FRAC_BITS:0]         factor;
    logic [2*WT_W-1:0]          prod;
    logic signed [POS_W-1:0]    pos;
    logic signed [POS_W+STR_W:0] term;

    if (j == 0) begin : g_in
      assign sv[j] = inject;
      assign sw[j] = W_ONE;
      assign si[j] = '0;
      assign sc[j] = corner_r;
    end else begin : g_pipe
      assign sv[j] = pv_r[j-1];
      assign sw[j] = pw_r[j-1];
      assign si[j] = pi_r[j-1];
      assign sc[j] = pc_r[j-1];
    end

    always_comb begin
      factor = sc[j][j] ? {1'b0, item_r.fr[j]} : (W_ONE - {1'b0, item_r.fr[j]});
      prod   = sw[j] * factor;
      nw[j]  = prod[FRAC_BITS +: WT_W];
      pos    = $signed({2'b00, item_r.ip[j]}) + $signed(POS_W'(sc[j][j]))
               - $signed(POS_W'(1));
      term   = pos * $signed({1'b0, stride_r[j]});
      ni[j]  = si[j] + IDX_W'(term);
    end

    always_ff @(posedge clk) begin
      pw_r[j] <= nw[j];
      pi_r[j] <= ni[j];
      pc_r[j] <= sc[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) pv_r[j] <= 1'b0;
      else        pv_r[j] <= sv[j];
    end
  end

  always_comb begin
    pipe_busy = 1'b0;
    for (int j = 0; j < DIMS; j++) pipe_busy = pipe_busy | pv_r[j];
  end

  // Corner check: skip zero weight, drop out-of-store index.
  logic [WT_W-1:0]         fw;
  logic signed [IDX_W-1:0] fi;
  logic                    fv, nz, in_rng;
  logic [PROD_W-1:0]       prod0, prod1;
  logic [CON_W-1:0]        con0, con1;

  always_comb begin
    fv     = pv_r[DIMS-1];
    fw     = pw_r[DIMS-1];
    fi     = pi_r[DIMS-1];
    nz     = (fw != '0);
    in_rng = (fi >= 0) && (fi < $signed(IDX_W'(GRID_DEPTH)));
    prod0  = fw * item_r.val0;
    prod1  = fw * item_r.val1;
    con0   = (CON_W'(prod0) >> CSHR) << CSHL;
    con1   = (NUM_CLASSES > 1) ? ((CON_W'(prod1) >> CSHR) << CSHL) : '0;
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    deq         = 1'b0;
    start_splat = 1'b0;
    start_read  = 1'b0;
    inject      = 1'b0;
    unique case (state_r)
      WK_IDLE: begin
        if (!q_empty && !stat.clearing && settle_r == '0 && !pipe_busy) begin
          if (head.is_read) begin
            if (!stat.out_full && !(req_r.vld && req_r.rd)) begin
              deq        = 1'b1;
              start_read = 1'b1;
            end
          end else begin
            deq         = 1'b1;
            start_splat = 1'b1;
            state_nxt   = WK_SPLAT;
          end
        end
      end
      WK_SPLAT: begin
        inject = 1'b1;
        if (corner_r == '1) state_nxt = WK_IDLE;
      end
      default: state_nxt = WK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= WK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (start_splat) begin
      item_r   <= head;
      corner_r <= '0;
    end else if (inject) begin
      corner_r <= corner_r + 1'b1;
    end
  end

  // Issue one store access per surviving corner or read.
  always_ff @(posedge clk) begin
    req_r.sticky <= sticky_r;
    if (start_read) begin
      req_r.zero <= !(32'(head.vertex) < 32'(GRID_DEPTH));
      req_r.addr <= ADDR_W'(head.vertex);
      req_r.con0 <= '0;
      req_r.con1 <= '0;
    end else begin
      req_r.zero <= 1'b0;
      req_r.addr <= ADDR_W'(fi);
      req_r.con0 <= SUM_W'(con0);
      req_r.con1 <= SUM_W'(con1);
    end
    if (!rst_n) begin
      sticky_r  <= 1'b0;
      req_r.vld <= 1'b0;
      req_r.rd  <= 1'b0;
    end else begin
      if (fv && nz && !in_rng) sticky_r <= 1'b1;
      req_r.vld <= start_read || (fv && nz && in_rng);
      req_r.rd  <= start_read;
    end
  end

  assign req = req_r;

endmodule

### hdl/bgs_accum.sv
// Grid store with clearing pass, read-modify-write with bypass and
// saturation, and the result register. Depends on bgs_pkg.
module bgs_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  bgs_pkg::acc_req_t   req,
  output bgs_pkg::acc_stat_t  stat,
  output logic                out_empty,
  input  logic                out_pop,
  output bgs_pkg::out_item_t  out_item
);
  import bgs_pkg::*;

  logic [2*SUM_W-1:0] mem [GRID_DEPTH];
  logic [2*SUM_W-1:0] rdata_r, byp_data_r, base, wdata;
  logic               byp_r;
  logic               w_vld_r, w_rd_r, w_zero_r, w_sticky_r;
  logic [ADDR_W-1:0]  w_addr_r;
  logic [SUM_W-1:0]   w_con0_r, w_con1_r;
  logic               clearing_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               out_vld_r;
  out_item_t          out_r;
  logic [SUM_W:0]     s0, s1;
  logic [SUM_W-1:0]   r0, r1;

  always_comb begin
    base  = byp_r ? byp_data_r : rdata_r;
    s0    = {1'b0, base[2*SUM_W-1:SUM_W]} + {1'b0, w_con0_r};
    s1    = {1'b0, base[SUM_W-1:0]} + {1'b0, w_con1_r};
    r0    = s0[SUM_W] ? '1 : s0[SUM_W-1:0];
    r1    = s1[SUM_W] ? '1 : s1[SUM_W-1:0];
    wdata = {r0, r1};
  end

  always_ff @(posedge clk) begin
    if (req.vld) rdata_r <= mem[req.addr];
    if (clearing_r)                 mem[clr_cnt_r] <= '0;
    else if (w_vld_r && !w_rd_r)    mem[w_addr_r]  <= wdata;
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wdata;
    w_rd_r     <= req.rd;
    w_zero_r   <= req.zero;
    w_sticky_r <= req.sticky;
    w_addr_r   <= req.addr;
    w_con0_r   <= req.con0;
    w_con1_r   <= req.con1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r    <= 1'b0;
      byp_r      <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      w_vld_r <= req.vld;
      byp_r   <= req.vld && w_vld_r && !w_rd_r && (req.addr == w_addr_r);
      if (clearing_r) begin
        if (clr_cnt_r == ADDR_W'(GRID_DEPTH - 1)) clearing_r <= 1'b0;
        else clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (w_vld_r && w_rd_r) out_vld_r <= 1'b1;
      else if (out_pop)      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (w_vld_r && w_rd_r) begin
      out_r.sum_class0   <= w_zero_r ? '0 : base[2*SUM_W-1:SUM_W];
      out_r.sum_class1   <= (w_zero_r || NUM_CLASSES < 2) ? '0 : base[SUM_W-1:0];
      out_r.dropped_flag <= w_sticky_r;
    end
  end

  assign stat.clearing = clearing_r;
  assign stat.out_full = out_vld_r || (w_vld_r && w_rd_r);
  assign out_empty     = !out_vld_r;
  assign out_item      = out_r;

endmodule

### hdl/bilateral_grid_splat_unit.sv
// Bilateral grid splat unit: top level joining front queue, corner walker
// and grid accumulator. Depends on bgs_pkg, bgs_front, bgs_walk, bgs_accum.
//
// Use:
//   Input is a queue: drive in_item and raise in_push while in_full is low.
//   A splat beat (req_type 0) adds weight * value of one point into those
//   2^DIMS corners of its grid cell that lie in the store and returns nothing.
//   A read beat (req_type 1) returns the two sums of one vertex and the sticky
//   drop flag. Results wait on out_item while out_empty is low; pop takes one.
//   Size registers are written on the cfg channel (cfg_ready is always high)
//   only while the unit is idle (a user rule, not enforced); strides settle.
// Walker: a splat holds it for a start step, one corner into the weight
//   pipeline per cycle, then the drain of the DIMS-stage weight/index
//   pipeline; the single store port takes one read-modify-write per kept
//   corner. An idle walker passes a read beat from the queue through req_r
//   and the write stage to the result register, which lowers out_empty.
// Reset: rst_n is synchronous. Afterwards a clearing pass zeros the store one
//   entry a cycle over GRID_DEPTH (65536) entries, with in_full held high.
// Stall: if results are not popped, one result is held and the next read
//   beat waits at the head of the two-entry queue; beats behind it wait too.
module bilateral_grid_splat_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  bgs_pkg::in_item_t              in_item,
  output logic                           out_empty,
  input  logic                           out_pop,
  output bgs_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgs_pkg::SIZE_W-1:0]     cfg_data
);
  import bgs_pkg::*;

  work_t     head;
  logic      q_empty, deq;
  acc_req_t  req;
  acc_stat_t stat;

  // Always take register writes.
  assign cfg_ready = 1'b1;

  // Accept and classify beats; hold them in a short queue.
  bgs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .clearing (stat.clearing),
    .deq      (deq),
    .q_empty  (q_empty),
    .head     (head)
  );

  // Walk corners, form weights and indices, drop out-of-store corners.
  bgs_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .head      (head),
    .deq       (deq),
    .stat      (stat),
    .req       (req)
  );

  // Accumulate into the store and hold the read result.
  bgs_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .stat      (stat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### hdl/bgs_checker.sv
// Port-level checks of the bilateral grid splat unit and their bind.
// Depends on bgs_pkg and bilateral_grid_splat_unit.
module bgs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input bgs_pkg::out_item_t             out_item
);
  import bgs_pkg::*;

  // A waiting result holds until popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while waiting");

  // The clearing pass blocks input right after reset.
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input open during clearing pass");

  // No result comes out of reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // A waiting drop flag never falls before it is popped.
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop && out_item.dropped_flag |=> out_item.dropped_flag)
    else $error("drop flag fell");

endmodule

bind bilateral_grid_splat_unit bgs_checker u_chk (.*);

### verif/bgs_checker.sv
// Checker for bilateral_grid_splat_unit: keeps its own grid, predicts read results.
// Watches the input, result and size-register channels. Depends on bgs_pkg.
module bgs_scoreboard (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  bgs_pkg::in_item_t              in_item,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  bgs_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgs_pkg::SIZE_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             outstanding,
  output int                             splat_count,
  output int                             result_count
);
  import bgs_pkg::*;

  localparam longint SUM_MAX = (longint'(1) << SUM_W) - 1;

  bit [SUM_W-1:0]    grid_sum0 [GRID_DEPTH];
  bit [SUM_W-1:0]    grid_sum1 [GRID_DEPTH];
  bit                drop_seen;
  logic [SIZE_W-1:0] dim_size [NUM_CFG];
  out_item_t         expected_reads [$];

  assign outstanding = expected_reads.size();

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    return (s > SUM_MAX) ? SUM_MAX : s;
  endfunction

  // Add one point into every corner of its cell, dropping corners off the store.
  function automatic void splat_into_grid(in_item_t it);
    longint           stride [DIMS];
    logic [COORD_W-1:0] crd [DIMS];
    longint           ipart, frac, w, idx, con0, con1, s;
    longint           one;
    bit               up;
    one = longint'(1) << FRAC_BITS;
    crd[0] = it.coord_d0; crd[1] = it.coord_d1; crd[2] = it.coord_d2;
    crd[3] = it.coord_d3; crd[4] = it.coord_d4; crd[5] = it.coord_d5;
    crd[6] = it.coord_d6;
    s = 1;
    for (int j = 0; j < DIMS; j++) begin
      stride[j] = s;
      s = s * longint'(dim_size[j]);
    end
    for (int c = 0; c < (1 << DIMS); c++) begin
      w = one;
      idx = 0;
      for (int j = 0; j < DIMS; j++) begin
        up = c[j];
        ipart = longint'(crd[j]) >> FRAC_BITS;
        frac = longint'(crd[j]) & (one - 1);
        w = (w * (up ? frac : one - frac)) >> FRAC_BITS;
        idx += (ipart + (up ? 1 : 0) - 1) * stride[j];
      end
      if (w == 0) continue;
      if (idx < 0 || idx >= GRID_DEPTH) begin
        drop_seen = 1'b1;
        continue;
      end
      con0 = w * longint'(it.value_class0);
      con1 = w * longint'(it.value_class1);
      if (FRAC_BITS >= 8) begin
        con0 = con0 >> CSHR;
        con1 = con1 >> CSHR;
      end else begin
        con0 = con0 << CSHL;
        con1 = con1 << CSHL;
      end
      grid_sum0[idx] = SUM_W'(sat_sum(longint'(grid_sum0[idx]), con0));
      if (NUM_CLASSES > 1)
        grid_sum1[idx] = SUM_W'(sat_sum(longint'(grid_sum1[idx]), con1));
    end
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      for (int k = 0; k < NUM_CFG; k++) dim_size[k] = SIZE_RESET;
      drop_seen = 1'b0;
      fail_count <= 0;
      splat_count <= 0;
      result_count <= 0;
    end else begin
      // Compare a popped beat before taking the new input beat.
      if (out_pop && !out_empty) begin
        result_count <= result_count + 1;
        if (expected_reads.size() == 0) begin
          $error("result beat with nothing expected");
          errs++;
        end else begin
          exp_item = expected_reads.pop_front();
          if (out_item.sum_class0 !== exp_item.sum_class0) begin
            $error("sum_class0 expected %0d got %0d", exp_item.sum_class0,
                   out_item.sum_class0);
            errs++;
          end
          if (out_item.sum_class1 !== exp_item.sum_class1) begin
            $error("sum_class1 expected %0d got %0d", exp_item.sum_class1,
                   out_item.sum_class1);
            errs++;
          end
          if (out_item.dropped_flag !== exp_item.dropped_flag) begin
            $error("dropped_flag expected %0d got %0d", exp_item.dropped_flag,
                   out_item.dropped_flag);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (in_push && !in_full) begin
        if (in_item.req_type == REQ_READ) begin
          exp_item.sum_class0 = '0;
          exp_item.sum_class1 = '0;
          if (in_item.vertex_index < GRID_DEPTH) begin
            exp_item.sum_class0 = grid_sum0[in_item.vertex_index];
            exp_item.sum_class1 = (NUM_CLASSES > 1) ? grid_sum1[in_item.vertex_index] : '0;
          end
          exp_item.dropped_flag = drop_seen;
          expected_reads = {expected_reads, exp_item};
        end else begin
          splat_into_grid(in_item);
          splat_count <= splat_count + 1;
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_CFG)
        dim_size[cfg_index] = cfg_data;
    end
  end

endmodule

### verif/testbench.sv
// Top of the splat unit testbench: clock, reset, stimulus and verdict.
// Depends on bgs_pkg, bilateral_grid_splat_unit and bgs_scoreboard.
module testbench;
  import bgs_pkg::*;

  localparam int PHASE_ITEMS = 360;
  localparam int CYCLE_LIMIT = 3000000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  in_item_t          in_item;
  logic              out_empty;
  logic              out_pop = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  int fail_count, outstanding, splat_count, result_count;
  int idle_mode;       // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int cycle_count = 0;

  // Sizes as this side last programmed them, used to aim splats into the store.
  int     cur_size [NUM_CFG];
  int     recent_vertex [$];

  bilateral_grid_splat_unit dut (
    .clk, .rst_n, .in_push, .in_full, .in_item, .out_empty, .out_pop, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  bgs_scoreboard chk (
    .clk, .rst_n, .in_push, .in_full, .in_item, .out_empty, .out_pop, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .outstanding, .splat_count, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall pop at random according to the current idle mode.
  always @(posedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == 2) ? 45 : (idle_mode == 3) ? 9 : 0;
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: the reset clearing pass plus all splats fit well inside this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold push low for random idle cycles, then present the beat until taken.
  task automatic push_beat(in_item_t it);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 9 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
  endtask

  function automatic logic [COORD_W-1:0] pack_coord(int ipart, int frac);
    return {IP_W'(ipart), FRAC_BITS'(frac)};
  endfunction

  function automatic int pick_frac();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 0;
    if (r == 1) return (1 << FRAC_BITS) - 1;
    return $urandom_range((1 << FRAC_BITS) - 1);
  endfunction

  function automatic int pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(255);
  endfunction

  // Build a splat; aimed ones keep the floor corner inside the store.
  function automatic in_item_t make_splat(bit aimed);
    in_item_t it;
    int       ipart [DIMS];
    longint   stride [DIMS];
    longint   s, room, base, lim;
    s = 1;
    for (int j = 0; j < DIMS; j++) begin
      stride[j] = s;
      s = s * cur_size[j];
    end
    room = GRID_DEPTH - 1;
    base = 0;
    for (int j = DIMS - 1; j >= 0; j--) begin
      if (aimed) begin
        lim = cur_size[j] - 2;
        if (stride[j] > 0 && room / stride[j] < lim) lim = room / stride[j];
        if (stride[j] == 0) lim = (cur_size[j] > 2) ? cur_size[j] - 2 : 0;
        if (lim < 0) lim = 0;
        ipart[j] = 1 + $urandom_range(int'(lim));
        room -= (ipart[j] - 1) * stride[j];
        base += (ipart[j] - 1) * stride[j];
      end else begin
        ipart[j] = $urandom_range((1 << IP_W) - 1);
      end
    end
    it = '0;
    it.req_type = REQ_SPLAT;
    it.coord_d0 = pack_coord(ipart[0], pick_frac());
    it.coord_d1 = pack_coord(ipart[1], pick_frac());
    it.coord_d2 = pack_coord(ipart[2], pick_frac());
    it.coord_d3 = pack_coord(ipart[3], pick_frac());
    it.coord_d4 = pack_coord(ipart[4], pick_frac());
    it.coord_d5 = pack_coord(ipart[5], pick_frac());
    it.coord_d6 = pack_coord(ipart[6], pick_frac());
    it.value_class0 = VAL_W'(pick_value());
    it.value_class1 = VAL_W'(pick_value());
    it.vertex_index = VIDX_W'($urandom);
    if (aimed && base < GRID_DEPTH) begin
      recent_vertex = {recent_vertex, int'(base)};
      if (recent_vertex.size() > 16) void'(recent_vertex.pop_front());
    end
    return it;
  endfunction

  function automatic in_item_t make_read();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.req_type = REQ_READ;
    if (recent_vertex.size() > 0 && $urandom_range(9) < 6)
      it.vertex_index = VIDX_W'(recent_vertex[$urandom_range(recent_vertex.size() - 1)]
                                + $urandom_range(1));
    else
      it.vertex_index = VIDX_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_of(int vertex);
    in_item_t it;
    it = make_read();
    it.vertex_index = VIDX_W'(vertex);
    return it;
  endfunction

  // Drain every expected result, then let the walking splat and the queued
  // ones finish before touching sizes.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_sizes(int s0, int s1, int s2, int s3, int s4, int s5, int s6);
    int vals [NUM_CFG];
    vals = '{s0, s1, s2, s3, s4, s5, s6};
    for (int k = 0; k < NUM_CFG; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= SIZE_W'(vals[k]);
      do @(posedge clk); while (!cfg_ready);
      cur_size[k] = vals[k];
    end
    cfg_valid <= 1'b0;
    // Wait for the strides to settle after the last write.
    repeat (20) @(posedge clk);
    recent_vertex.delete();
  endtask

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      // Rotate the idle pattern every 40 beats.
      if (n % 40 == 0) idle_mode = (n / 40) % 4;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: push_beat(make_splat(1'b1));
        5:             push_beat(make_splat(1'b0));
        default:       push_beat(make_read());
      endcase
    end
    idle_mode = 0;
  endtask

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_mode = 0;
    for (int k = 0; k < NUM_CFG; k++) cur_size[k] = SIZE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-corner splat at the origin with full values.
    it = make_splat(1'b1);
    it.coord_d0 = pack_coord(1, 0); it.coord_d1 = pack_coord(1, 0);
    it.coord_d2 = pack_coord(1, 0); it.coord_d3 = pack_coord(1, 0);
    it.coord_d4 = pack_coord(1, 0); it.coord_d5 = pack_coord(1, 0);
    it.coord_d6 = pack_coord(1, 0);
    it.value_class0 = VAL_W'(255); it.value_class1 = VAL_W'(255);
    push_beat(it);
    push_beat(read_of(0));
    // Half-way fractions: many equal corners, and zero values.
    it.coord_d0 = pack_coord(1, 512); it.coord_d1 = pack_coord(2, 512);
    push_beat(it);
    it.value_class0 = '0; it.value_class1 = '0;
    push_beat(it);
    push_beat(read_of(0));
    push_beat(read_of(1));
    // Tiny fractions: most corner weights truncate to zero.
    it.value_class0 = VAL_W'(200); it.value_class1 = VAL_W'(7);
    it.coord_d0 = pack_coord(2, 1); it.coord_d1 = pack_coord(2, 1023);
    it.coord_d2 = pack_coord(3, 1);
    push_beat(it);
    push_beat(read_of(1 + 4 + 32));
    push_beat(read_of(65535));
    // Integer part zero: floor corner lands below the store.
    it.coord_d3 = pack_coord(0, 300);
    push_beat(it);
    push_beat(read_of(0));
    // All-ones coordinates: far past the end of the store.
    it.coord_d0 = '1; it.coord_d1 = '1; it.coord_d2 = '1; it.coord_d3 = '1;
    it.coord_d4 = '1; it.coord_d5 = '1; it.coord_d6 = '1;
    push_beat(it);
    push_beat(read_of(0));

    random_phase(PHASE_ITEMS);
    settle();
    write_sizes(2, 2, 2, 2, 2, 2, 2);
    random_phase(PHASE_ITEMS);
    settle();
    write_sizes(16, 16, 16, 16, 16, 16, 16);
    random_phase(PHASE_ITEMS);
    settle();
    write_sizes($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(2, 16),
                $urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(2, 16),
                $urandom_range(2, 16));
    random_phase(PHASE_ITEMS);
    settle();
    // Sizes outside the meant range are used as given.
    write_sizes(31, 0, 1, 15, 3, 31, 0);
    random_phase(PHASE_ITEMS / 2);
    settle();
    write_sizes(8, 3, 16, 2, 5, 4, 2);
    random_phase(PHASE_ITEMS);

    settle();
    $display("covered %0d splats and %0d read results over six size settings",
             splat_count, result_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, outstanding);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bgs_pkg.sv
hdl/bgs_front.sv
hdl/bgs_walk.sv
hdl/bgs_accum.sv
hdl/bilateral_grid_splat_unit.sv
hdl/bgs_checker.sv
verif/bgs_checker.sv
verif/testbench.sv
